@@ sv/jes_pkg.sv @@
// Shared types and constants of the job execution supervisor.
package jes_pkg;

	// Event kinds as they arrive on the input channel.
	typedef enum logic [2:0] {
		EV_START    = 3'd0,
		EV_ACCEPTED = 3'd1,
		EV_FEEDBACK = 3'd2,
		EV_CANCEL   = 3'd3,
		EV_CHECK    = 3'd4,
		EV_FAIL     = 3'd5,
		EV_BACKEND  = 3'd6,
		EV_RESET    = 3'd7
	} kind_t;

	// Lifecycle phase of the job, also the job_state output coding.
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_WAIT      = 4'd1,
		PH_EXEC      = 4'd2,
		PH_CANCELING = 4'd3,
		PH_SUCCEEDED = 4'd4,
		PH_REJECTED  = 4'd5,
		PH_FAILED    = 4'd6,
		PH_CANCELED  = 4'd7,
		PH_TIMED_OUT = 4'd8,
		PH_STALE     = 4'd9
	} phase_t;

	// Watchdog event coding.
	typedef enum logic [1:0] {
		WD_NONE     = 2'd0,
		WD_EXEC     = 2'd1,
		WD_STALE    = 2'd2,
		WD_CANCEL   = 2'd3
	} wd_t;

	// Backend terminal results after classification.
	typedef enum logic [2:0] {
		BR_SUCCEEDED = 3'd0,
		BR_REJECTED  = 3'd1,
		BR_CANCELED  = 3'd2,
		BR_ABORTED   = 3'd3,
		BR_UNKNOWN   = 3'd4
	} bres_t;

	// Terminal codes.
	localparam logic [3:0] CODE_NONE      = 4'd0;
	localparam logic [3:0] CODE_SUCCEEDED = 4'd1;
	localparam logic [3:0] CODE_INVALID   = 4'd2;
	localparam logic [3:0] CODE_NOT_READY = 4'd3;
	localparam logic [3:0] CODE_BUSY      = 4'd4;
	localparam logic [3:0] CODE_REJECTED  = 4'd6;
	localparam logic [3:0] CODE_ABORTED   = 4'd7;
	localparam logic [3:0] CODE_CANCELED  = 4'd8;
	localparam logic [3:0] CODE_TIMED_OUT = 4'd9;
	localparam logic [3:0] CODE_STALE     = 4'd10;
	localparam logic [3:0] CODE_INTERNAL  = 4'd11;

	// Cancel causes.
	localparam logic [1:0] CAUSE_OTHER = 2'd0;
	localparam logic [1:0] CAUSE_EXEC  = 2'd1;
	localparam logic [1:0] CAUSE_STALE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_DEFAULT_TMO = 2'd0;
	localparam logic [1:0] REG_MAX_TMO     = 2'd1;
	localparam logic [1:0] REG_STALE_TMO   = 2'd2;
	localparam logic [1:0] REG_CANCEL_TMO  = 2'd3;

	// Configuration reset values.
	localparam logic [31:0] RST_DEFAULT_TMO = 32'd300000;
	localparam logic [31:0] RST_MAX_TMO     = 32'd600000;
	localparam logic [31:0] RST_STALE_TMO   = 32'd5000;
	localparam logic [31:0] RST_CANCEL_TMO  = 32'd10000;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// One classified event, without its time stamp.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] timeout;
		logic        fail_ok;
		logic        fail_rej;
		logic [3:0]  fail_code;
		logic [1:0]  cause;
		logic        reason;
		bres_t       bres;
	} event_t;

	// Watchdog limits that the back needs.
	typedef struct packed {
		logic [31:0] stale_tmo;
		logic [31:0] cancel_tmo;
	} wd_cfg_t;

endpackage

@@ sv/jes_front.sv @@
// Front end: configuration registers and classification of incoming events.
module jes_front import jes_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [2:0]           kind,
	input  logic [31:0]          now_ticks,
	input  logic [31:0]          requested_timeout,
	input  logic [3:0]           fail_code,
	input  logic [1:0]           cancel_cause,
	input  logic                 reason_given,
	input  logic [2:0]           backend_result,
	output event_t               ev,
	output logic [TIME_BITS-1:0] ev_now,
	output wd_cfg_t              wd_cfg
);

	logic [31:0] default_tmo_q;
	logic [31:0] max_tmo_q;
	logic [31:0] stale_tmo_q;
	logic [31:0] cancel_tmo_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_tmo_q <= RST_DEFAULT_TMO;
			max_tmo_q     <= RST_MAX_TMO;
			stale_tmo_q   <= RST_STALE_TMO;
			cancel_tmo_q  <= RST_CANCEL_TMO;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEFAULT_TMO: default_tmo_q <= cfg_data;
				REG_MAX_TMO:     max_tmo_q     <= cfg_data;
				REG_STALE_TMO:   stale_tmo_q   <= cfg_data;
				REG_CANCEL_TMO:  cancel_tmo_q  <= cfg_data;
			endcase
		end
	end

	assign wd_cfg.stale_tmo  = stale_tmo_q;
	assign wd_cfg.cancel_tmo = cancel_tmo_q;

	// Time stamps wrap at the configured time width.
	assign ev_now = TIME_BITS'(now_ticks);

	always_comb begin
		ev.kind      = kind_t'(kind);
		ev.fail_code = fail_code;
		ev.reason    = reason_given;

		// A zero request takes the default; anything else is clamped to the maximum.
		if (requested_timeout == 32'd0) begin
			ev.timeout = default_tmo_q;
		end else if (requested_timeout < max_tmo_q) begin
			ev.timeout = requested_timeout;
		end else begin
			ev.timeout = max_tmo_q;
		end

		ev.fail_ok  = reason_given && (fail_code >= CODE_INVALID) &&
			(fail_code <= CODE_INTERNAL);
		ev.fail_rej = (fail_code == CODE_INVALID) || (fail_code == CODE_NOT_READY) ||
			(fail_code == CODE_BUSY) || (fail_code == CODE_REJECTED);

		// The unused cause code counts as other.
		ev.cause = (cancel_cause == CAUSE_EXEC || cancel_cause == CAUSE_STALE) ?
			cancel_cause : CAUSE_OTHER;

		unique case (backend_result)
			BR_SUCCEEDED: ev.bres = BR_SUCCEEDED;
			BR_REJECTED:  ev.bres = BR_REJECTED;
			BR_CANCELED:  ev.bres = BR_CANCELED;
			BR_ABORTED:   ev.bres = BR_ABORTED;
			default:      ev.bres = BR_UNKNOWN;
		endcase
	end

endmodule

@@ sv/jes_queue.sv @@
// Short queue of classified events between the front and the back.
module jes_queue import jes_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	cnt_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

@@ sv/jes_back.sv @@
// Back end: job state, watchdogs and the registered result.
module jes_back import jes_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  event_t               ev,
	input  logic [TIME_BITS-1:0] now,
	input  wd_cfg_t              wd_cfg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 accepted,
	output logic [1:0]           watchdog_event,
	output logic [3:0]           job_state,
	output logic [3:0]           exit_code,
	output logic                 is_terminal,
	output logic                 release_owner,
	output logic                 backend_pending,
	output logic                 cancel_flag,
	output logic [31:0]          limit_ticks
);

	localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

	phase_t               phase_q, n_phase;
	logic [3:0]           code_q, n_code;
	logic                 cancel_q, n_cancel;
	logic                 term_q, n_term;
	logic                 rel_q, n_rel;
	logic                 pend_q, n_pend;
	logic                 bk_q, n_bk;
	logic [31:0]          limit_q, n_limit;
	logic [TIME_BITS-1:0] acc_time_q, n_acc_time;
	logic [TIME_BITS-1:0] fb_time_q, n_fb_time;
	logic [TIME_BITS-1:0] can_time_q, n_can_time;
	logic [TIME_BITS-1:0] ev_time_q, n_ev_time;
	logic [1:0]           cause_q, n_cause;
	logic                 n_acc;
	wd_t                  n_wd;

	logic                 out_valid_q;
	logic                 acc_q;
	wd_t                  wd_q;

	logic                 pop;
	logic                 ge_ev, gt_ev, ge_fb;
	logic                 can_ok;
	logic                 age_over, stale_over, cancel_over;
	logic [TIME_BITS-1:0] d_acc, d_fb, d_can;

	assign pop     = q_valid && (!out_valid_q || out_ready);
	assign q_ready = !out_valid_q || out_ready;

	// Elapsed times wrap at the time width, as the time stamps do.
	assign d_acc = now - acc_time_q;
	assign d_fb  = now - fb_time_q;
	assign d_can = now - can_time_q;

	assign ge_ev       = now >= ev_time_q;
	assign gt_ev       = now > ev_time_q;
	assign ge_fb       = now >= fb_time_q;
	assign age_over    = CW'(d_acc) > CW'(limit_q);
	assign stale_over  = CW'(d_fb) > CW'(wd_cfg.stale_tmo);
	assign cancel_over = CW'(d_can) > CW'(wd_cfg.cancel_tmo);
	assign can_ok      = (phase_q == PH_WAIT || phase_q == PH_EXEC) && !cancel_q && ge_ev;

	always_comb begin
		n_phase    = phase_q;
		n_code     = code_q;
		n_cancel   = cancel_q;
		n_term     = term_q;
		n_rel      = rel_q;
		n_pend     = pend_q;
		n_bk       = bk_q;
		n_limit    = limit_q;
		n_acc_time = acc_time_q;
		n_fb_time  = fb_time_q;
		n_can_time = can_time_q;
		n_ev_time  = ev_time_q;
		n_cause    = cause_q;
		n_acc      = 1'b0;
		n_wd       = WD_NONE;

		unique case (ev.kind)
			EV_START: begin
				if (phase_q == PH_IDLE) begin
					n_phase    = PH_WAIT;
					n_code     = CODE_NONE;
					n_cancel   = 1'b0;
					n_term     = 1'b0;
					n_rel      = 1'b0;
					n_pend     = 1'b0;
					n_bk       = 1'b0;
					n_cause    = CAUSE_OTHER;
					n_can_time = '0;
					n_limit    = ev.timeout;
					n_acc_time = now;
					n_fb_time  = now;
					n_ev_time  = now;
					n_acc      = 1'b1;
				end
			end
			EV_ACCEPTED: begin
				if (phase_q == PH_WAIT && ge_ev) begin
					n_phase    = PH_EXEC;
					n_bk       = 1'b1;
					n_acc_time = now;
					n_fb_time  = now;
					n_ev_time  = now;
					n_acc      = 1'b1;
				end
			end
			EV_FEEDBACK: begin
				if ((phase_q == PH_EXEC || phase_q == PH_CANCELING) && ge_fb) begin
					n_fb_time = now;
					if (gt_ev) begin
						n_ev_time = now;
					end
					n_acc = 1'b1;
				end
			end
			EV_CANCEL: begin
				if (ev.reason && can_ok) begin
					n_phase    = PH_CANCELING;
					n_cancel   = 1'b1;
					n_cause    = ev.cause;
					n_can_time = now;
					n_ev_time  = now;
					n_acc      = 1'b1;
				end
			end
			EV_CHECK: begin
				if (ge_ev) begin
					n_acc = 1'b1;
					if (phase_q == PH_EXEC && bk_q && (age_over || stale_over)) begin
						// The age watchdog wins over the stale one.
						n_wd = age_over ? WD_EXEC : WD_STALE;
						if (can_ok) begin
							n_phase    = PH_CANCELING;
							n_cancel   = 1'b1;
							n_cause    = age_over ? CAUSE_EXEC : CAUSE_STALE;
							n_can_time = now;
							n_ev_time  = now;
						end
					end else if (phase_q == PH_CANCELING && cancel_over) begin
						// Forced end; the backend result is still owed.
						n_phase = (cause_q == CAUSE_STALE) ? PH_STALE : PH_TIMED_OUT;
						n_code  = (cause_q == CAUSE_STALE) ? CODE_STALE : CODE_TIMED_OUT;
						n_term  = 1'b1;
						n_rel   = 1'b0;
						n_pend  = 1'b1;
						n_wd    = WD_CANCEL;
					end
				end
			end
			EV_FAIL: begin
				if (phase_q == PH_WAIT && ev.fail_ok) begin
					n_phase = ev.fail_rej ? PH_REJECTED : PH_FAILED;
					n_code  = ev.fail_code;
					n_term  = 1'b1;
					n_rel   = 1'b1;
					n_acc   = 1'b1;
				end
			end
			EV_BACKEND: begin
				if (pend_q) begin
					n_pend = 1'b0;
					n_rel  = 1'b1;
					n_acc  = 1'b1;
				end else if (!term_q && phase_q != PH_IDLE) begin
					n_term = 1'b1;
					n_rel  = 1'b1;
					n_acc  = 1'b1;
					unique case (ev.bres)
						BR_SUCCEEDED: begin
							n_phase = PH_SUCCEEDED;
							n_code  = CODE_SUCCEEDED;
						end
						BR_REJECTED: begin
							n_phase = PH_REJECTED;
							n_code  = CODE_REJECTED;
						end
						BR_CANCELED: begin
							if (cause_q == CAUSE_EXEC) begin
								n_phase = PH_TIMED_OUT;
								n_code  = CODE_TIMED_OUT;
							end else if (cause_q == CAUSE_STALE) begin
								n_phase = PH_STALE;
								n_code  = CODE_STALE;
							end else begin
								n_phase = PH_CANCELED;
								n_code  = CODE_CANCELED;
							end
						end
						BR_ABORTED: begin
							n_phase = PH_FAILED;
							n_code  = CODE_ABORTED;
						end
						default: begin
							n_phase = PH_FAILED;
							n_code  = CODE_INTERNAL;
						end
					endcase
				end
			end
			default: begin
				n_phase    = PH_IDLE;
				n_code     = CODE_NONE;
				n_cancel   = 1'b0;
				n_term     = 1'b0;
				n_rel      = 1'b0;
				n_pend     = 1'b0;
				n_bk       = 1'b0;
				n_cause    = CAUSE_OTHER;
				n_limit    = '0;
				n_acc_time = '0;
				n_fb_time  = '0;
				n_can_time = '0;
				n_ev_time  = '0;
				n_acc      = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			code_q     <= CODE_NONE;
			cancel_q   <= 1'b0;
			term_q     <= 1'b0;
			rel_q      <= 1'b0;
			pend_q     <= 1'b0;
			bk_q       <= 1'b0;
			limit_q    <= '0;
			acc_time_q <= '0;
			fb_time_q  <= '0;
			can_time_q <= '0;
			ev_time_q  <= '0;
			cause_q    <= CAUSE_OTHER;
		end else if (pop) begin
			phase_q    <= n_phase;
			code_q     <= n_code;
			cancel_q   <= n_cancel;
			term_q     <= n_term;
			rel_q      <= n_rel;
			pend_q     <= n_pend;
			bk_q       <= n_bk;
			limit_q    <= n_limit;
			acc_time_q <= n_acc_time;
			fb_time_q  <= n_fb_time;
			can_time_q <= n_can_time;
			ev_time_q  <= n_ev_time;
			cause_q    <= n_cause;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The result fields that are not job state are held with the beat.
	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q <= n_acc;
			wd_q  <= n_wd;
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = acc_q;
	assign watchdog_event  = wd_q;
	assign job_state       = phase_q;
	assign exit_code       = code_q;
	assign is_terminal     = term_q;
	assign release_owner   = rel_q;
	assign backend_pending = pend_q;
	assign cancel_flag     = cancel_q;
	assign limit_ticks     = limit_q;

	pend_needs_term: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (term_q && !rel_q))
		else $error("backend pending without a withheld terminal outcome");

	term_phase: assert property (@(posedge clk) disable iff (!arst_n)
		term_q |-> (phase_q != PH_IDLE && phase_q != PH_WAIT &&
			phase_q != PH_EXEC && phase_q != PH_CANCELING))
		else $error("terminal flag in a live phase");

	wd_means_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && wd_q != WD_NONE) |-> acc_q)
		else $error("watchdog event on an ignored check");

	cancel_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cancel_q |-> (phase_q != PH_IDLE))
		else $error("cancel flag while idle");

endmodule

@@ sv/job_execution_supervisor_unit.sv @@
// Top level of the job execution supervisor.
//
// Usage: events enter on the in_valid/in_ready channel, one beat per event,
// with the kind, time stamp and kind-specific fields on their own ports.
// Each event yields exactly one result beat on out_valid/out_ready, in order.
// The four watchdog and timeout registers are written through the
// cfg_valid/cfg_ready channel (index 0 default timeout, 1 maximum timeout,
// 2 stale feedback limit, 3 cancel limit); cfg_ready is always high and
// writes belong in quiet periods with no events in flight.
// An accepted event is written into the queue; the back end takes it from
// the queue once nothing waits ahead of it and no result is held back, and
// registers its result, which is presented until the receiver takes it.
// Throughput: one event per cycle while results are taken, set by the update in
// the back end, which compares the time stamp against all stored times in
// parallel. The front end classifies an event as it is accepted and places
// it in a four-beat queue, so input keeps flowing while a result waits to be
// taken; when the receiver holds out_ready low the presented result stays
// unchanged, up to four more events collect, and then in_ready falls.
// Reset (arst_n low) empties the queue, drops any pending result, returns
// the job to idle and reloads the registers with their default values.
module job_execution_supervisor_unit import jes_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [31:0] now_ticks,
	input  logic [31:0] requested_timeout,
	input  logic [3:0]  fail_code,
	input  logic [1:0]  cancel_cause,
	input  logic        reason_given,
	input  logic [2:0]  backend_result,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [1:0]  watchdog_event,
	output logic [3:0]  job_state,
	output logic [3:0]  exit_code,
	output logic        is_terminal,
	output logic        release_owner,
	output logic        backend_pending,
	output logic        cancel_flag,
	output logic [31:0] limit_ticks
);

	localparam int EV_W = $bits(event_t);
	localparam int Q_W  = EV_W + TIME_BITS;

	event_t               front_ev;
	logic [TIME_BITS-1:0] front_now;
	wd_cfg_t              wd_cfg;

	logic                 q_valid;
	logic                 q_ready;
	logic [Q_W-1:0]       q_data;

	// The front end holds the registers and decodes each beat as it arrives.
	jes_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.kind              (kind),
		.now_ticks         (now_ticks),
		.requested_timeout (requested_timeout),
		.fail_code         (fail_code),
		.cancel_cause      (cancel_cause),
		.reason_given      (reason_given),
		.backend_result    (backend_result),
		.ev                (front_ev),
		.ev_now            (front_now),
		.wd_cfg            (wd_cfg)
	);

	// Classified events wait here until the back end can take them.
	jes_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_ready (in_ready),
		.wr_data  ({front_now, front_ev}),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_data)
	);

	// The back end applies one event per cycle while results are taken, and registers its result.
	jes_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_ready         (q_ready),
		.ev              (event_t'(q_data[EV_W-1:0])),
		.now             (q_data[Q_W-1:EV_W]),
		.wd_cfg          (wd_cfg),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.accepted        (accepted),
		.watchdog_event  (watchdog_event),
		.job_state       (job_state),
		.exit_code       (exit_code),
		.is_terminal     (is_terminal),
		.release_owner   (release_owner),
		.backend_pending (backend_pending),
		.cancel_flag     (cancel_flag),
		.limit_ticks     (limit_ticks)
	);

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the job execution supervisor: job lifecycles against a local model.
module tb_top;
	import jes_pkg::*;

	// Cycles with no beat on any channel before the run is declared hung.
	localparam int QUIET_LIMIT = 2000;
	// Length of the long receiver stall used to fill the event queue.
	localparam int HOLD_CYCLES = 60;

	// One event as the sender drives it, every field on its own port.
	typedef struct {
		kind_t       k;
		logic [31:0] tick;
		logic [31:0] req;
		logic [3:0]  fc;
		logic [1:0]  cause;
		logic        reason;
		logic [2:0]  br;
	} job_event_t;

	// One result beat, field for field as the block presents it.
	typedef struct {
		logic        acc;
		wd_t         wd;
		phase_t      st;
		logic [3:0]  code;
		logic        term;
		logic        rel;
		logic        pend;
		logic        canc;
		logic [31:0] tmo;
	} job_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = '0;
	logic [31:0] now_ticks = '0;
	logic [31:0] requested_timeout = '0;
	logic [3:0]  fail_code = '0;
	logic [1:0]  cancel_cause = '0;
	logic        reason_given = 1'b0;
	logic [2:0]  backend_result = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        accepted;
	logic [1:0]  watchdog_event;
	logic [3:0]  job_state;
	logic [3:0]  exit_code;
	logic        is_terminal;
	logic        release_owner;
	logic        backend_pending;
	logic        cancel_flag;
	logic [31:0] limit_ticks;

	job_execution_supervisor_unit dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Local copy of the timeout registers, tracked as they are written.
	logic [31:0] lim_default = RST_DEFAULT_TMO;
	logic [31:0] lim_max     = RST_MAX_TMO;
	logic [31:0] lim_stale   = RST_STALE_TMO;
	logic [31:0] lim_cancel  = RST_CANCEL_TMO;

	// Local copy of the job: phase, outcome, flags and the stored times.
	phase_t      job_phase_q = PH_IDLE;
	logic [3:0]  job_code_q = CODE_NONE;
	logic        fl_cancel = 1'b0;
	logic        fl_term = 1'b0;
	logic        fl_rel = 1'b0;
	logic        fl_pend = 1'b0;
	logic        fl_backend = 1'b0;
	logic [1:0]  job_cause_q = CAUSE_OTHER;
	logic [31:0] job_limit_q = '0;
	logic [31:0] t_accept = '0;
	logic [31:0] t_feedback = '0;
	logic [31:0] t_cancel = '0;
	logic [31:0] t_event = '0;

	// Results the block still owes, oldest first.
	job_status_t status_due[$];

	int  items_sent = 0;
	int  results_seen = 0;
	int  n_errors = 0;
	int  quiet_cycles = 0;
	bit  gaps_on = 1'b1;
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	int  rx_wait = 0;
	bit  out_fire = 1'b0;

	// Stimulus time base and how far it moves per event in the current phase.
	logic [31:0] cur_tick = '0;
	logic [31:0] tick_scale = 32'd3000;
	logic [31:0] jump_scale = 32'd700000;

	function automatic void clear_job();
		job_phase_q = PH_IDLE;
		job_code_q = CODE_NONE;
		{fl_cancel, fl_term, fl_rel, fl_pend, fl_backend} = '0;
		job_cause_q = CAUSE_OTHER;
		job_limit_q = '0;
		t_accept = '0;
		t_feedback = '0;
		t_cancel = '0;
		t_event = '0;
	endfunction

	// Reaching a public outcome always sets the terminal flag; the release flag
	// follows the caller, so a watchdog outcome holds ownership until the backend ends.
	function automatic void finish_job(phase_t ph, logic [3:0] code, logic rel);
		job_phase_q = ph;
		job_code_q = code;
		fl_term = 1'b1;
		fl_rel = rel;
	endfunction

	// A cancel only takes hold while waiting or executing, once, and never back in time.
	// An unknown cause is kept as other.
	function automatic logic begin_cancel(logic [31:0] tick, logic [1:0] cause);
		if ((job_phase_q != PH_WAIT && job_phase_q != PH_EXEC) || fl_cancel || tick < t_event)
			return 1'b0;
		job_phase_q = PH_CANCELING;
		fl_cancel = 1'b1;
		job_cause_q = (cause > CAUSE_STALE) ? CAUSE_OTHER : cause;
		t_cancel = tick;
		t_event = tick;
		return 1'b1;
	endfunction

	// Applies one event to the local job and returns the status beat it must produce.
	function automatic job_status_t advance_job(job_event_t e);
		logic        acc;
		wd_t         wd;
		logic [31:0] lim;
		logic [31:0] exec_age;
		logic [31:0] fb_age;
		logic [31:0] cancel_age;
		logic        rej;
		job_status_t r;
		acc = 1'b0;
		wd = WD_NONE;
		exec_age = e.tick - t_accept;
		fb_age = e.tick - t_feedback;
		cancel_age = e.tick - t_cancel;
		case (e.k)
			EV_START: begin
				if (job_phase_q == PH_IDLE) begin
					// Zero picks the default; anything else is clamped to the maximum.
					lim = (e.req == '0) ? lim_default : ((e.req < lim_max) ? e.req : lim_max);
					clear_job();
					job_phase_q = PH_WAIT;
					job_limit_q = lim;
					t_accept = e.tick;
					t_event = e.tick;
					t_feedback = e.tick;
					acc = 1'b1;
				end
			end
			EV_ACCEPTED: begin
				if (job_phase_q == PH_WAIT && e.tick >= t_event) begin
					job_phase_q = PH_EXEC;
					fl_backend = 1'b1;
					t_accept = e.tick;
					t_feedback = e.tick;
					t_event = e.tick;
					acc = 1'b1;
				end
			end
			EV_FEEDBACK: begin
				if ((job_phase_q == PH_EXEC || job_phase_q == PH_CANCELING) &&
						e.tick >= t_feedback) begin
					t_feedback = e.tick;
					if (e.tick > t_event)
						t_event = e.tick;
					acc = 1'b1;
				end
			end
			EV_CANCEL: begin
				if (e.reason)
					acc = begin_cancel(e.tick, e.cause);
			end
			EV_CHECK: begin
				// A check is taken whenever time has not gone back. The execution age
				// wins over staleness, and the cancel deadline only matters while canceling.
				if (e.tick >= t_event) begin
					acc = 1'b1;
					if (job_phase_q == PH_EXEC && fl_backend && exec_age > job_limit_q) begin
						void'(begin_cancel(e.tick, CAUSE_EXEC));
						wd = WD_EXEC;
					end else if (job_phase_q == PH_EXEC && fl_backend && fb_age > lim_stale) begin
						void'(begin_cancel(e.tick, CAUSE_STALE));
						wd = WD_STALE;
					end else if (job_phase_q == PH_CANCELING && cancel_age > lim_cancel) begin
						if (job_cause_q == CAUSE_STALE)
							finish_job(PH_STALE, CODE_STALE, 1'b0);
						else
							finish_job(PH_TIMED_OUT, CODE_TIMED_OUT, 1'b0);
						fl_pend = 1'b1;
						wd = WD_CANCEL;
					end
				end
			end
			EV_FAIL: begin
				if (job_phase_q == PH_WAIT && e.fc >= CODE_INVALID && e.fc <= CODE_INTERNAL &&
						e.reason) begin
					rej = (e.fc == CODE_INVALID) || (e.fc == CODE_NOT_READY) ||
						(e.fc == CODE_BUSY) || (e.fc == CODE_REJECTED);
					finish_job(rej ? PH_REJECTED : PH_FAILED, e.fc, 1'b1);
					acc = 1'b1;
				end
			end
			EV_BACKEND: begin
				// A backend end that was already awaited by a forced outcome only
				// frees ownership; otherwise it decides the outcome itself.
				if (fl_pend) begin
					fl_pend = 1'b0;
					fl_rel = 1'b1;
					acc = 1'b1;
				end else if (!fl_term && job_phase_q != PH_IDLE) begin
					case (e.br)
						BR_SUCCEEDED: finish_job(PH_SUCCEEDED, CODE_SUCCEEDED, 1'b1);
						BR_REJECTED:  finish_job(PH_REJECTED, CODE_REJECTED, 1'b1);
						BR_CANCELED: begin
							if (job_cause_q == CAUSE_EXEC)
								finish_job(PH_TIMED_OUT, CODE_TIMED_OUT, 1'b1);
							else if (job_cause_q == CAUSE_STALE)
								finish_job(PH_STALE, CODE_STALE, 1'b1);
							else
								finish_job(PH_CANCELED, CODE_CANCELED, 1'b1);
						end
						BR_ABORTED:   finish_job(PH_FAILED, CODE_ABORTED, 1'b1);
						default:      finish_job(PH_FAILED, CODE_INTERNAL, 1'b1);
					endcase
					acc = 1'b1;
				end
			end
			default: begin
				clear_job();
				acc = 1'b1;
			end
		endcase
		r.acc = acc;
		r.wd = wd;
		r.st = job_phase_q;
		r.code = job_code_q;
		r.term = fl_term;
		r.rel = fl_rel;
		r.pend = fl_pend;
		r.canc = fl_cancel;
		r.tmo = job_limit_q;
		return r;
	endfunction

	// An event of the given kind and time with every other field random.
	function automatic job_event_t rand_event(kind_t k, logic [31:0] tick);
		job_event_t e;
		e.k = k;
		e.tick = tick;
		e.req = $urandom();
		e.fc = 4'($urandom_range(0, 15));
		e.cause = 2'($urandom_range(0, 3));
		e.reason = 1'($urandom_range(0, 1));
		e.br = 3'($urandom_range(0, 7));
		return e;
	endfunction

	// Moves the stimulus clock: mostly small steps, sometimes a long jump,
	// sometimes a step back so that the time check gets exercised.
	function automatic logic [31:0] next_tick();
		case ($urandom_range(0, 15))
			0:       cur_tick = cur_tick - $urandom_range(1, 50);
			1:       cur_tick = cur_tick + $urandom_range(0, jump_scale);
			default: cur_tick = cur_tick + $urandom_range(0, tick_scale);
		endcase
		return cur_tick;
	endfunction

	// Requested timeouts: zero, in range, fully random, or right around the maximum.
	function automatic logic [31:0] pick_request();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return $urandom_range(1, lim_max);
			2:       return $urandom();
			default: return lim_max + $urandom_range(0, 2) - 1;
		endcase
	endfunction

	// Sends one event beat. The gap before it is drawn per event; with no gap
	// valid simply stays high and only the payload moves on.
	task automatic send_event(input job_event_t e);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= e.k;
		now_ticks <= e.tick;
		requested_timeout <= e.req;
		fail_code <= e.fc;
		cancel_cause <= e.cause;
		reason_given <= e.reason;
		backend_result <= e.br;
		// Inputs only move at rising edges, so what is seen at the falling edge
		// is exactly what the next rising edge will take.
		do
			@(negedge clk);
		while (!in_ready);
		status_due.push_back(advance_job(e));
		items_sent++;
		@(posedge clk);
	endtask

	// Holds the sender back until every owed result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high so that back-to-back writes need no second assignment.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(negedge clk);
		while (!cfg_ready);
		case (idx)
			REG_DEFAULT_TMO: lim_default = data;
			REG_MAX_TMO:     lim_max = data;
			REG_STALE_TMO:   lim_stale = data;
			default:         lim_cancel = data;
		endcase
		@(posedge clk);
	endtask

	// Writes all four limits; only called once the block has nothing in flight.
	task automatic load_limits(input logic [31:0] dflt, mx, stale, cncl);
		write_reg(REG_DEFAULT_TMO, dflt);
		write_reg(REG_MAX_TMO, mx);
		write_reg(REG_STALE_TMO, stale);
		write_reg(REG_CANCEL_TMO, cncl);
		cfg_valid <= 1'b0;
	endtask

	// One job from start to its end, with random content and timing. Some jobs
	// are replaced by bursts of arbitrary events, and some skip steps.
	task automatic run_job();
		job_event_t e;
		int n_mid;
		int i;
		int pick;
		kind_t k;
		gaps_on = ($urandom_range(0, 4) != 0);
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 1) == 0)
					cur_tick = $urandom();
				send_event(rand_event(kind_t'($urandom_range(0, 7)), next_tick()));
			end
			return;
		end
		if (job_phase_q != PH_IDLE && $urandom_range(0, 5) != 0)
			send_event(rand_event(EV_RESET, next_tick()));
		if ($urandom_range(0, 3) == 0)
			cur_tick = $urandom();
		e = rand_event(EV_START, next_tick());
		e.req = pick_request();
		send_event(e);
		if ($urandom_range(0, 5) == 0) begin
			e = rand_event(EV_FAIL, next_tick());
			if ($urandom_range(0, 4) != 0)
				e.fc = 4'($urandom_range(CODE_INVALID, CODE_INTERNAL));
			e.reason = ($urandom_range(0, 5) != 0);
			send_event(e);
		end else if ($urandom_range(0, 9) != 0) begin
			send_event(rand_event(EV_ACCEPTED, next_tick()));
		end
		n_mid = $urandom_range(2, 10);
		for (i = 0; i < n_mid; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 8)
				k = EV_FEEDBACK;
			else if (pick < 15)
				k = EV_CHECK;
			else if (pick < 17)
				k = EV_CANCEL;
			else if (pick < 19)
				k = EV_BACKEND;
			else
				k = kind_t'($urandom_range(0, 7));
			e = rand_event(k, next_tick());
			if (k == EV_CANCEL)
				e.reason = ($urandom_range(0, 7) != 0);
			send_event(e);
		end
		if ($urandom_range(0, 1) == 0)
			send_event(rand_event(EV_BACKEND, next_tick()));
	endtask

	task automatic run_jobs(input int n);
		int stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at)
			run_job();
		gaps_on = 1'b1;
	endtask

	// Walks each watchdog, the clamp and the odd field values by hand, at the reset limits.
	task automatic test_directed_lifecycle();
		job_event_t e;
		e = rand_event(EV_START, 32'd100);
		e.req = '0;
		send_event(e);
		send_event(rand_event(EV_ACCEPTED, 32'd50));      // time going back is ignored
		send_event(rand_event(EV_ACCEPTED, 32'd200));
		send_event(rand_event(EV_FEEDBACK, 32'd300));
		send_event(rand_event(EV_CHECK, 32'd5301));       // feedback one tick too old
		send_event(rand_event(EV_CHECK, 32'd15302));      // cancel deadline passed, stale outcome
		send_event(rand_event(EV_BACKEND, 32'd15400));    // late backend end frees ownership
		send_event(rand_event(EV_RESET, 32'd0));
		e = rand_event(EV_START, 32'd1000);
		e.req = '1;                                       // clamped to the maximum
		send_event(e);
		send_event(rand_event(EV_ACCEPTED, 32'd1000));
		send_event(rand_event(EV_CHECK, 32'd601001));     // execution age over the limit
		e = rand_event(EV_BACKEND, 32'd601002);
		e.br = BR_CANCELED;
		send_event(e);
		e = rand_event(EV_START, 32'hFFFF_FFFE);          // start while not idle
		e.req = 32'd5;
		send_event(e);
		send_event(rand_event(EV_RESET, 32'd0));
		send_event(e);
		e = rand_event(EV_FAIL, 32'hFFFF_FFFE);
		e.fc = '1;                                        // code out of range
		e.reason = 1'b1;
		send_event(e);
		e.fc = CODE_BUSY;                                 // no reason given
		e.reason = 1'b0;
		send_event(e);
		e = rand_event(EV_FAIL, 32'hFFFF_FFFF);
		e.fc = CODE_ABORTED;
		e.reason = 1'b1;
		send_event(e);
		send_event(rand_event(EV_RESET, 32'd0));
		e = rand_event(EV_START, 32'd20);
		e.req = '0;
		send_event(e);
		e = rand_event(EV_CANCEL, 32'd20);
		e.cause = '1;                                     // unknown cause counts as other
		e.reason = 1'b1;
		send_event(e);
		send_event(rand_event(EV_CHECK, 32'd10021));      // cancel deadline with cause other
		send_event(rand_event(EV_BACKEND, 32'd10022));
		send_event(rand_event(EV_RESET, 32'd0));
		send_event(rand_event(EV_START, 32'd0));
		e = rand_event(EV_BACKEND, 32'd1);
		e.br = '1;                                        // unknown backend result
		send_event(e);
		drain();
	endtask

	task automatic test_reset_limits();
		tick_scale = 32'd3000;
		jump_scale = 32'd700000;
		run_jobs(240);
		drain();
	endtask

	// Short limits, plus a long receiver stall while events keep coming so that
	// the queue fills and in_ready has to drop.
	task automatic test_short_limits();
		int i;
		load_limits(32'd20, 32'd50, 32'd15, 32'd30);
		tick_scale = 32'd10;
		jump_scale = 32'd60;
		gaps_on = 1'b0;
		hold_req = 1'b1;
		for (i = 0; i < 30; i++)
			send_event(rand_event(kind_t'($urandom_range(0, 7)), next_tick()));
		drain();
		gaps_on = 1'b1;
		run_jobs(210);
		drain();
	endtask

	task automatic test_minimum_limits();
		load_limits(32'd1, 32'd1, 32'd1, 32'd1);
		tick_scale = 32'd3;
		jump_scale = 32'd4;
		run_jobs(240);
		drain();
	endtask

	// All-ones limits: no age can exceed them, and times roam the whole range.
	task automatic test_maximum_limits();
		load_limits('1, '1, '1, '1);
		tick_scale = 32'h1000_0000;
		jump_scale = '1;
		run_jobs(240);
		drain();
	endtask

	// Zero limits and a maximum below the default are used exactly as written.
	task automatic test_inconsistent_limits();
		load_limits(32'd100, 32'd10, 32'd0, 32'd0);
		tick_scale = 32'd20;
		jump_scale = 32'd200;
		run_jobs(120);
		drain();
		load_limits(32'd0, 32'd0, 32'd7, 32'd3);
		run_jobs(120);
		drain();
	endtask

	task automatic test_random_limits();
		load_limits($urandom_range(1, 1 << 16), $urandom_range(1, 1 << 17),
			$urandom_range(1, 1 << 12), $urandom_range(1, 1 << 13));
		tick_scale = 32'd2000;
		jump_scale = 32'd200000;
		run_jobs(240);
		drain();
	endtask

	// Receiver: after each beat it takes, it draws a short pause; a requested
	// hold-off overrides that and is counted down here, cycle by cycle.
	always @(posedge clk) begin
		if (out_fire)
			rx_wait = gaps_on ? $urandom_range(0, 3) : 0;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result checker. It looks at the falling edge, where ports are settled,
	// and compares the beat that the next rising edge will take.
	always @(negedge clk) begin
		out_fire = arst_n && out_valid && out_ready;
		if (out_fire) begin
			results_seen++;
			if (status_due.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("result %0d arrived with no event owing it", results_seen);
			end else if (status_due[0].acc !== accepted || status_due[0].wd !== watchdog_event ||
					status_due[0].st !== job_state || status_due[0].code !== exit_code ||
					status_due[0].term !== is_terminal || status_due[0].rel !== release_owner ||
					status_due[0].pend !== backend_pending ||
					status_due[0].canc !== cancel_flag ||
					status_due[0].tmo !== limit_ticks) begin
				n_errors++;
				if (n_errors <= 10) begin
					$display("result %0d mismatch", results_seen);
					$display("  exp acc=%0d wd=%0d st=%0d code=%0d t=%0d r=%0d p=%0d c=%0d tmo=%0d",
						status_due[0].acc, status_due[0].wd, status_due[0].st,
						status_due[0].code, status_due[0].term, status_due[0].rel,
						status_due[0].pend, status_due[0].canc, status_due[0].tmo);
					$display("  act acc=%0d wd=%0d st=%0d code=%0d t=%0d r=%0d p=%0d c=%0d tmo=%0d",
						accepted, watchdog_event, job_state, exit_code, is_terminal,
						release_owner, backend_pending, cancel_flag, limit_ticks);
				end
			end
			if (status_due.size() != 0)
				void'(status_due.pop_front());
		end
	end

	// Hang detector: any beat on any channel resets the count.
	always @(negedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no beat moved for %0d cycles, %0d results still owed",
				quiet_cycles, status_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lifecycle();
		test_reset_limits();
		test_short_limits();
		test_minimum_limits();
		test_maximum_limits();
		test_inconsistent_limits();
		test_random_limits();
		drain();
		// A few more cycles so that a stray extra beat would still be caught.
		repeat (20) @(posedge clk);
		if (n_errors == 0 && status_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
sv/jes_pkg.sv
sv/jes_front.sv
sv/jes_queue.sv
sv/jes_back.sv
sv/job_execution_supervisor_unit.sv
bench/tb_top.sv
